// File: hw/rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, register codes and the fixed colour palette of the fire
// strip renderer.
// ----------------------------------------------------------------------------
package lfr_pkg;

	// field widths
	localparam int SEED_W       = 8;
	localparam int HEAT_W       = 7;
	localparam int LED_IDX_W    = 6;
	localparam int CHAN_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int PALETTE_SIZE = 128;

	// item kinds
	localparam logic KIND_SEED  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOUD_SEED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_SECOND = 2'd2;

	// register reset values
	localparam logic [SEED_W-1:0] LOUD_SEED_RST    = 8'd128;
	localparam logic [SEED_W-1:0] QUIET_FIRST_RST  = 8'd0;
	localparam logic [SEED_W-1:0] QUIET_SECOND_RST = 8'd10;

	// floor(9*x/20) as (x * COOL_RECIP) >> COOL_SHIFT, exact for x up to 510
	localparam int              COOL_SUM_W  = SEED_W + 1;
	localparam int              COOL_RECIP_W = 15;
	localparam int              COOL_SHIFT  = 16;
	localparam logic [COOL_RECIP_W-1:0] COOL_RECIP = 15'd29493;
	localparam int              COOL_PROD_W = COOL_SUM_W + COOL_RECIP_W;
	localparam logic [HEAT_W-1:0] HEAT_MAX  = 7'd127;

	// input request
	typedef struct packed {
		logic kind;
		logic beat;
	} item_t;

	// output request
	typedef struct packed {
		logic [LED_IDX_W-1:0] led_index;
		logic [CHAN_W-1:0]    red;
		logic [CHAN_W-1:0]    green;
		logic [CHAN_W-1:0]    blue;
		logic                 last_led;
	} colour_t;

	// sequencer to output stage
	typedef struct packed {
		logic [HEAT_W-1:0]    heat;
		logic [LED_IDX_W-1:0] led_index;
		logic                 last_led;
	} heat_req_t;

	typedef logic [3*CHAN_W-1:0] palette_t [PALETTE_SIZE];

	// integer hsl palette: hue idx/5, full saturation, lightness min(2*idx,128)
	function automatic palette_t build_palette();
		palette_t    tab;
		int unsigned hue;
		int unsigned lum;
		int unsigned v;
		int unsigned m;
		int unsigned vsf;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		for (int i = 0; i < PALETTE_SIZE; i++) begin
			hue = (i * 205) >> 10;
			lum = (i * 2 > 128) ? 128 : i * 2;
			if (lum < 128) begin
				v = (lum * 511) >> 8;
			end else begin
				v = (((lum + 255) << 8) - lum * 255) >> 8;
			end
			if (v == 0) begin
				tab[i] = '0;
			end else begin
				m   = lum + lum - v;
				vsf = (hue * 6 * (v - m)) >> 8;
				r   = v & 255;
				g   = (m + vsf) & 255;
				b   = m & 255;
				if (g == 1) begin
					g = 0;
				end
				if (b == 1) begin
					b = 0;
				end
				tab[i] = {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
			end
		end
		return tab;
	endfunction

	localparam palette_t PALETTE = build_palette();

endpackage

// File: hw/rtl/led_fire_strip_renderer.sv
// ----------------------------------------------------------------------------
// led_fire_strip_renderer
// Fire effect for an LED strip: seed cells, a row of heat cells and a
// palette lookup, one LED per cycle while the colour output does not stall.
// ----------------------------------------------------------------------------
// A seed request (kind 0) loads the two seed cells from the loud register on
// a beat, otherwise from the two quiet registers; it gives no colour. A frame
// request (kind 1) walks the heat row once: the sequencer handles one cell
// per cycle while the output stage has room, reading the old value from the
// heat RAM, cooling the two cells before it through the single multiplier
// unit and writing the new value back; the input stays stalled until the
// walk ends. Each colour passes the heat stage register and then the colour
// register; colours come out for heat cells 0 .. LED_COUNT-1, i.e. LED
// LED_COUNT-1 down to LED 0, and last_led marks LED 0. The heat RAM needs no
// clearing pass: it reads as zero until the first frame has rewritten every
// cell. Configuration writes are always taken and must only be issued while
// the block is idle.
module led_fire_strip_renderer #(
	parameter int LED_COUNT = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lfr_pkg::item_t                  item,
	input  logic                            item_valid,
	output logic                            item_stall,
	output lfr_pkg::colour_t                colour,
	output logic                            colour_valid,
	input  logic                            colour_stall,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfr_pkg::SEED_W-1:0]      cfg_data
);
	import lfr_pkg::*;

	localparam int AW = $clog2(LED_COUNT);

	typedef enum logic {
		ST_IDLE,
		ST_STEP
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      cnt_q;
	logic               init_q;
	logic [SEED_W-1:0]  p2_q;
	logic [SEED_W-1:0]  p1_q;
	logic [SEED_W-1:0]  seed0_q;
	logic [SEED_W-1:0]  seed1_q;
	logic [SEED_W-1:0]  loud_q;
	logic [SEED_W-1:0]  quiet_first_q;
	logic [SEED_W-1:0]  quiet_second_q;

	logic               item_acc;
	logic               step_ready;
	logic               step_go;
	logic               step_last;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [HEAT_W-1:0]  ram_rdata;
	logic [HEAT_W-1:0]  old_heat;
	logic [HEAT_W-1:0]  new_heat;
	heat_req_t          heat_req;

	// handshakes
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// one cell per cycle while the output stage has room
	assign step_go   = (state_q == ST_STEP) && step_ready;
	assign step_last = (cnt_q == AW'(LED_COUNT - 1));

	// read one cell ahead of the write; idle keeps cell 0 preloaded
	assign ram_re    = (state_q == ST_IDLE) || (step_go && !step_last);
	assign ram_raddr = (state_q == ST_STEP) ? cnt_q + AW'(1) : '0;

	// cells never written since reset read as zero
	assign old_heat = init_q ? ram_rdata : '0;

	lfr_ram #(
		.WIDTH (HEAT_W),
		.DEPTH (LED_COUNT)
	) u_heat_ram (
		.clk   (clk),
		.we    (step_go),
		.waddr (cnt_q),
		.wdata (new_heat),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lfr_cooler u_cool (
		.older (p2_q),
		.newer (p1_q),
		.heat  (new_heat)
	);

	// cooled cell to the palette stage
	always_comb begin
		heat_req.heat      = new_heat;
		heat_req.led_index = LED_IDX_W'(LED_COUNT - 1) - LED_IDX_W'(cnt_q);
		heat_req.last_led  = step_last;
	end

	lfr_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (step_go),
		.req          (heat_req),
		.req_ready    (step_ready),
		.colour       (colour),
		.colour_valid (colour_valid),
		.colour_stall (colour_stall)
	);

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			init_q  <= 1'b0;
			p2_q    <= '0;
			p1_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && item.kind == KIND_FRAME) begin
						state_q <= ST_STEP;
						cnt_q   <= '0;
						p2_q    <= seed0_q;
						p1_q    <= seed1_q;
					end
				end
				ST_STEP: begin
					if (step_go) begin
						p2_q <= p1_q;
						p1_q <= SEED_W'(old_heat);
						if (step_last) begin
							state_q <= ST_IDLE;
							init_q  <= 1'b1;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
			endcase
		end
	end

	// seed cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed0_q <= '0;
			seed1_q <= '0;
		end else if (item_acc && item.kind == KIND_SEED) begin
			if (item.beat) begin
				seed0_q <= loud_q;
				seed1_q <= loud_q;
			end else begin
				seed0_q <= quiet_first_q;
				seed1_q <= quiet_second_q;
			end
		end
	end

	// configuration registers, unused index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loud_q         <= LOUD_SEED_RST;
			quiet_first_q  <= QUIET_FIRST_RST;
			quiet_second_q <= QUIET_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOUD_SEED:    loud_q         <= cfg_data;
				CFG_QUIET_FIRST:  quiet_first_q  <= cfg_data;
				CFG_QUIET_SECOND: quiet_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a frame request starts the walk at cell 0 and holds the input
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.kind == KIND_FRAME |=> item_stall && cnt_q == '0)
		else $error("frame did not start at cell 0");

	// the walk never writes past the last cell
	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |-> cnt_q <= AW'(LED_COUNT - 1))
		else $error("heat cell index out of range");

	// the final cell releases the input
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && step_last |=> !item_stall)
		else $error("sequencer did not return to idle after last cell");

	// the frame's last colour belongs to LED 0
	a_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid && colour.last_led |-> colour.led_index == '0)
		else $error("last colour not at LED 0");

endmodule

// File: hw/rtl/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/lfr_cooler.sv
// ----------------------------------------------------------------------------
// lfr_cooler
// Shared cooling unit: heat = min(floor(9*(older+newer)/20), 127), done as
// one constant multiply by a scaled reciprocal.
// ----------------------------------------------------------------------------
module lfr_cooler (
	input  logic [lfr_pkg::SEED_W-1:0] older,
	input  logic [lfr_pkg::SEED_W-1:0] newer,
	output logic [lfr_pkg::HEAT_W-1:0] heat
);
	import lfr_pkg::*;

	logic [COOL_SUM_W-1:0]          sum;
	logic [COOL_PROD_W-1:0]         prod;
	logic [COOL_PROD_W-COOL_SHIFT-1:0] quot;

	// sum of the two cells before this one
	assign sum  = COOL_SUM_W'(older) + COOL_SUM_W'(newer);

	// scaled reciprocal multiply
	assign prod = COOL_PROD_W'(sum) * COOL_PROD_W'(COOL_RECIP);
	assign quot = prod[COOL_PROD_W-1:COOL_SHIFT];

	// saturate to the heat range
	assign heat = (quot > (COOL_PROD_W-COOL_SHIFT)'(HEAT_MAX)) ? HEAT_MAX : quot[HEAT_W-1:0];

endmodule

// File: hw/rtl/lfr_out_stage.sv
// ----------------------------------------------------------------------------
// lfr_out_stage
// Holds one cooled heat value, maps it through the palette and keeps the
// colour in an output register that waits on the downstream stall.
// ----------------------------------------------------------------------------
module lfr_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  lfr_pkg::heat_req_t  req,
	output logic                req_ready,
	output lfr_pkg::colour_t    colour,
	output logic                colour_valid,
	input  logic                colour_stall
);
	import lfr_pkg::*;

	heat_req_t            h_s1;
	logic                 h_valid_s1;
	colour_t              colour_q;
	logic                 colour_valid_q;
	logic                 out_free;
	logic                 h_move;
	logic [3*CHAN_W-1:0]  pal;

	// output register can take a new colour this cycle
	assign out_free  = !colour_valid_q || !colour_stall;
	assign h_move    = h_valid_s1 && out_free;
	assign req_ready = !h_valid_s1 || out_free;

	// palette lookup
	assign pal = PALETTE[h_s1.heat];

	// heat stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_s1 <= 1'b0;
		end else if (req_valid) begin
			h_valid_s1 <= 1'b1;
		end else if (h_move) begin
			h_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			h_s1 <= req;
		end
	end

	// colour register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_valid_q <= 1'b0;
		end else if (h_move) begin
			colour_valid_q <= 1'b1;
		end else if (!colour_stall) begin
			colour_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (h_move) begin
			colour_q.led_index <= h_s1.led_index;
			colour_q.red       <= pal[3*CHAN_W-1:2*CHAN_W];
			colour_q.green     <= pal[2*CHAN_W-1:CHAN_W];
			colour_q.blue      <= pal[CHAN_W-1:0];
			colour_q.last_led  <= h_s1.last_led;
		end
	end

	assign colour       = colour_q;
	assign colour_valid = colour_valid_q;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the fire strip renderer against its own prediction. Seed and frame
// requests go in, and configuration writes are made only while the block is
// idle. Every colour that comes out is compared field by field with the next
// colour the scoreboard expects. A directed opening runs first, then random
// phases with and without idling, and one long output hold-off that makes
// the block stall its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfr_pkg::*;

	localparam int LED_COUNT   = 48;
	localparam int SETTLE      = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// expected colour stream of the strip
	class fire_scoreboard;
		logic [SEED_W-1:0]     loud;
		logic [SEED_W-1:0]     quiet_first;
		logic [SEED_W-1:0]     quiet_second;
		logic [SEED_W-1:0]     seeds [2];
		logic [HEAT_W-1:0]     heat [LED_COUNT];
		logic [3*CHAN_W-1:0]   flame_colours [PALETTE_SIZE];
		colour_t               pending_colours [$];
		int                    errors;

		function new();
			int unsigned hue;
			int unsigned lum;
			int unsigned peak;
			int unsigned base;
			int unsigned gr;
			int unsigned bl;
			loud         = LOUD_SEED_RST;
			quiet_first  = QUIET_FIRST_RST;
			quiet_second = QUIET_SECOND_RST;
			seeds[0]     = '0;
			seeds[1]     = '0;
			errors       = 0;
			foreach (heat[j]) begin
				heat[j] = '0;
			end
			// hsl palette, full saturation, first hue sextant only
			for (int i = 0; i < PALETTE_SIZE; i++) begin
				hue  = i / 5;
				lum  = (2 * i < 128) ? 2 * i : 128;
				peak = (lum == 128) ? 255 : (lum * 511) / 256;
				if (peak == 0) begin
					flame_colours[i] = '0;
				end else begin
					base = 2 * lum - peak;
					gr   = (base + (hue * 6 * (peak - base)) / 256) % 256;
					bl   = base % 256;
					if (gr == 1) begin
						gr = 0;
					end
					if (bl == 1) begin
						bl = 0;
					end
					flame_colours[i] = {peak[7:0], gr[7:0], bl[7:0]};
				end
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [SEED_W-1:0] val);
			case (idx)
				CFG_LOUD_SEED: begin
					loud = val;
				end
				CFG_QUIET_FIRST: begin
					quiet_first = val;
				end
				CFG_QUIET_SECOND: begin
					quiet_second = val;
				end
				default: begin
				end
			endcase
		endfunction

		// accepted request: load seeds or advance the heat row one frame
		function void note_item(item_t it);
			logic [HEAT_W-1:0] fresh [LED_COUNT];
			int unsigned       lo;
			int unsigned       hi;
			int unsigned       cooled;
			colour_t           c;
			if (it.kind == KIND_SEED) begin
				seeds[0] = it.beat ? loud : quiet_first;
				seeds[1] = it.beat ? loud : quiet_second;
				return;
			end
			// every cell from the two old cells before it, seeds standing left of cell 0
			for (int j = 0; j < LED_COUNT; j++) begin
				lo       = (j >= 2) ? 32'(heat[j-2]) : 32'(seeds[j]);
				hi       = (j >= 1) ? 32'(heat[j-1]) : 32'(seeds[1]);
				cooled   = ((lo + hi) * 9) / 20;
				fresh[j] = (cooled > HEAT_MAX) ? HEAT_MAX : cooled[HEAT_W-1:0];
			end
			heat = fresh;
			for (int j = 0; j < LED_COUNT; j++) begin
				c.led_index = LED_IDX_W'(LED_COUNT - 1 - j);
				{c.red, c.green, c.blue} = flame_colours[heat[j]];
				c.last_led  = (j == LED_COUNT - 1);
				pending_colours.push_back(c);
			end
		endfunction

		function void check_colour(colour_t got);
			colour_t want;
			if (pending_colours.size() == 0) begin
				$display("%0t unexpected colour: idx %0d rgb %02x %02x %02x last %0b",
					$time, got.led_index, got.red, got.green, got.blue, got.last_led);
				errors++;
				return;
			end
			want = pending_colours.pop_front();
			if (got.led_index !== want.led_index || got.red !== want.red ||
				got.green !== want.green || got.blue !== want.blue ||
				got.last_led !== want.last_led) begin
				$display("%0t colour mismatch: expected idx %0d rgb %02x %02x %02x last %0b",
					$time, want.led_index, want.red, want.green, want.blue, want.last_led);
				$display("%0t                  actual   idx %0d rgb %02x %02x %02x last %0b",
					$time, got.led_index, got.red, got.green, got.blue, got.last_led);
				errors++;
			end
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	item_t                item         = '0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	colour_t              colour;
	logic                 colour_valid;
	logic                 colour_stall = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [SEED_W-1:0]    cfg_data     = '0;

	fire_scoreboard sb = new();

	int send_pct    = 0;
	int stall_pct   = 0;
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int cycles      = 0;

	led_fire_strip_renderer #(
		.LED_COUNT(LED_COUNT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.colour      (colour),
		.colour_valid(colour_valid),
		.colour_stall(colour_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// colour receiver: random stall, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			colour_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			colour_stall <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			hold_served  <= hold_served + 1;
		end else begin
			colour_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// colour monitor
	always @(posedge clk) begin
		if (arst_n && colour_valid && !colour_stall) begin
			sb.check_colour(colour);
		end
	end

	// offer one request, idling first at random; valid stays high after acceptance
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		sb.note_item(it);
	endtask

	task automatic send_kind(logic kind, logic beat);
		item_t it;
		it.kind = kind;
		it.beat = beat;
		send_item(it);
	endtask

	function automatic item_t random_item();
		item_t it;
		it.kind = ($urandom_range(99) < 25) ? KIND_SEED : KIND_FRAME;
		it.beat = 1'($urandom_range(1));
		return it;
	endfunction

	// register write; valid stays high so back-to-back writes need no gap
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEED_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.write_register(idx, val);
	endtask

	task automatic write_seeds(logic [SEED_W-1:0] loud, logic [SEED_W-1:0] first,
		logic [SEED_W-1:0] second);
		write_reg(CFG_LOUD_SEED, loud);
		write_reg(CFG_QUIET_FIRST, first);
		write_reg(CFG_QUIET_SECOND, second);
		write_reg(CFG_UNUSED, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SEED_W-1:0] random_seed();
		return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(128));
	endfunction

	// drop valid and wait for every colour, plus a margin for a trailing seed request
	task automatic wait_quiet();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_colours.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cold strip, quiet and loud seeds at reset settings
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_SEED, 1'b0);
		send_kind(KIND_FRAME, 1'b1);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_SEED, 1'b1);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_FRAME, 1'b1);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_SEED, 1'b0);
		send_kind(KIND_FRAME, 1'b0);
		wait_quiet();

		// full-scale registers drive the heat into saturation
		write_seeds(8'd255, 8'd255, 8'd255);
		send_kind(KIND_SEED, 1'b1);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_FRAME, 1'b1);
		send_kind(KIND_SEED, 1'b0);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_FRAME, 1'b0);
		wait_quiet();

		// all-zero registers let the strip cool down
		write_seeds(8'd0, 8'd0, 8'd0);
		send_kind(KIND_SEED, 1'b1);
		send_kind(KIND_FRAME, 1'b0);
		send_kind(KIND_SEED, 1'b0);
		send_kind(KIND_FRAME, 1'b1);
		wait_quiet();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < 4; p++) begin
			write_seeds(random_seed(), random_seed(), random_seed());
			send_pct  = (p == 1) ? 67 : (p == 3) ? 11 : 0;
			stall_pct <= (p == 2) ? 67 : (p == 3) ? 11 : 0;
			repeat (22) send_item(random_item());
			wait_quiet();
		end

		// long output hold-off while frames keep coming
		write_seeds(8'd128, 8'($urandom_range(128)), 8'($urandom_range(128)));
		send_pct   = 0;
		stall_pct  <= 0;
		hold_asked <= hold_asked + 1;
		send_kind(KIND_SEED, 1'b1);
		repeat (12) send_kind(KIND_FRAME, 1'($urandom_range(1)));
		wait_quiet();

		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
